[rtl/core/msde_pkg.sv]
package msde_pkg;

  // Number of debounced switches (8 to 64); flip and occupancy always span 64 bits
  localparam int NumSwitches = 64;
  localparam int WordW       = 64;
  localparam int CntW        = 8;
  localparam int SquareW     = 6;
  localparam int ModeW       = 2;
  localparam int CntAddrW    = (NumSwitches > 1) ? $clog2(NumSwitches) : 1;
  localparam int WalkIdxW    = $clog2(NumSwitches + 1);
  localparam int PaddrW      = 4;
  localparam int PdataW      = 32;

  // Item modes; the fourth code means nothing and is ignored
  typedef enum logic [ModeW-1:0] {
    ModeTick   = 2'd0,
    ModeStart  = 2'd1,
    ModeResume = 2'd2
  } mode_e;

  // Register indexes (byte address / 4)
  localparam logic [1:0] RegDrop = 2'd0;
  localparam logic [1:0] RegLift = 2'd1;
  localparam logic [1:0] RegFlip = 2'd2;
  localparam logic [1:0] RegPoll = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StEmit
  } state_e;

  // Counter write request
  typedef struct packed {
    logic                en;
    logic [CntAddrW-1:0] addr;
    logic [CntW-1:0]     data;
  } cnt_wr_t;

  function automatic logic [WordW-1:0] rev_word(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    for (int k = 0; k < WordW; k++) begin
      r[k] = v[WordW-1-k];
    end
    return r;
  endfunction

endpackage

[rtl/core/msde_if.sv]
// Command channel: one item per poll tick or mode change
interface msde_cmd_if
  import msde_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ModeW-1:0]   mode;
  logic [WordW-1:0]   raw_rows;

  modport source (output valid, mode, raw_rows, input ready);
  modport sink   (input valid, mode, raw_rows, output ready);
endinterface

// Event channel: one item per debounced change
interface msde_evt_if
  import msde_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SquareW-1:0] square;
  logic               lifted;
  logic               last_event;
  logic [WordW-1:0]   occupancy;

  modport source (output valid, square, lifted, last_event, occupancy, input ready);
  modport sink   (input valid, square, lifted, last_event, occupancy, output ready);
endinterface

[rtl/core/msde_cnt_bank.sv]
// Per-switch change counters: one memory, registered read, valid bit per entry.
// An entry whose valid bit is clear reads as zero, so a bulk clear only resets the valid bits.
module msde_cnt_bank
  import msde_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clr_all_i,
  input  logic [CntAddrW-1:0] rd_addr_i,
  input  cnt_wr_t             wr_i,
  output logic [CntW-1:0]     rd_data_o
);

  logic [CntW-1:0]        mem_q [NumSwitches];
  logic [NumSwitches-1:0] vld_q;
  logic [CntW-1:0]        rdata_q;
  logic                   rvld_q;

  // storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[rd_addr_i];
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr_i];
      if (clr_all_i) begin
        vld_q <= '0;
      end else if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

[rtl/core/multi_switch_debounce_events_unit.sv]
// 64-switch counter debouncer. A tick item (mode 0, polling enabled) latches the
// raw word (optionally bit-reversed, then inverted) and walks the switch counters
// one per cycle through a single counter memory and one increment/compare unit.
// Then an event scan visits one switch per cycle, unless the output slot is full,
// in ascending order and presents each change on the event channel with the
// occupancy map of the finished tick; scanning ends after the last change.
// Start, resume, undefined modes and ticks with polling off are taken while idle
// and give no event. The command channel is not ready while a tick is in progress.
module multi_switch_debounce_events_unit
  import msde_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  msde_cmd_if.sink          cmd_i,
  msde_evt_if.source        evt_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  state_e state_q, state_d;

  logic [CntW-1:0]        drop_thr_q, lift_thr_q;
  logic                   flip_q, poll_q;
  logic [WordW-1:0]       deb_q, sample_q;
  logic [NumSwitches-1:0] chg_q;
  logic [WalkIdxW-1:0]    rd_idx_q;
  logic                   s1_vld_q;
  logic [CntAddrW-1:0]    s1_idx_q;
  logic [CntAddrW-1:0]    emit_idx_q;

  logic                   evt_vld_q;
  logic [SquareW-1:0]     evt_sq_q;
  logic                   evt_lift_q;
  logic                   evt_last_q;
  logic [WordW-1:0]       evt_occ_q;

  logic                   cmd_fire, cfg_wr, walk_rd, walk_done;
  logic                   tick_go, clr_all;
  logic                   emit_load, emit_skip, slot_free;
  logic [CntW-1:0]        cnt_rd, cnt_inc, cnt_thr;
  logic                   cur_bit, diff_bit, hit;
  logic [NumSwitches-1:0] emit_rest;
  cnt_wr_t                cnt_wr;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegDrop: prdata = PdataW'(drop_thr_q);
      RegLift: prdata = PdataW'(lift_thr_q);
      RegFlip: prdata = PdataW'(flip_q);
      RegPoll: prdata = PdataW'(poll_q);
      default: prdata = '0;
    endcase
  end

  // ---------------- command decode ----------------
  assign cmd_fire = cmd_i.valid && cmd_i.ready;

  always_comb begin
    tick_go = 1'b0;
    clr_all = 1'b0;
    if (cmd_fire) begin
      case (mode_e'(cmd_i.mode))
        ModeTick:   tick_go = poll_q;
        ModeStart:  clr_all = 1'b1;
        ModeResume: clr_all = 1'b1;
        default:    ;
      endcase
    end
  end

  // ---------------- FSM next state ----------------
  assign walk_done = (rd_idx_q == WalkIdxW'(NumSwitches)) && !s1_vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (tick_go) state_d = StWalk;
      StWalk:  if (walk_done) state_d = StEmit;
      StEmit:  if (chg_q == '0) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // ---------------- FSM outputs ----------------
  assign slot_free = !evt_vld_q || evt_o.ready;

  always_comb begin
    cmd_i.ready = 1'b0;
    walk_rd     = 1'b0;
    emit_load   = 1'b0;
    emit_skip   = 1'b0;
    unique case (state_q)
      StIdle: cmd_i.ready = 1'b1;
      StWalk: walk_rd = (rd_idx_q != WalkIdxW'(NumSwitches));
      StEmit: begin
        if (chg_q != '0) begin
          if (chg_q[emit_idx_q]) begin
            emit_load = slot_free;
          end else begin
            emit_skip = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // ---------------- shared update unit ----------------
  assign cur_bit  = deb_q[s1_idx_q];
  assign diff_bit = cur_bit ^ sample_q[s1_idx_q];
  assign cnt_inc  = cnt_rd + CntW'(1);
  assign cnt_thr  = cur_bit ? drop_thr_q : lift_thr_q;
  assign hit      = diff_bit && (cnt_inc >= cnt_thr);

  always_comb begin
    cnt_wr.en   = s1_vld_q;
    cnt_wr.addr = s1_idx_q;
    cnt_wr.data = (diff_bit && !hit) ? cnt_inc : '0;
  end

  msde_cnt_bank u_cnt_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_all_i (clr_all),
    .rd_addr_i (rd_idx_q[CntAddrW-1:0]),
    .wr_i      (cnt_wr),
    .rd_data_o (cnt_rd)
  );

  // remaining changes once the current one goes out
  assign emit_rest = chg_q & ~(NumSwitches'(1) << emit_idx_q);

  // ---------------- control and state registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      drop_thr_q <= CntW'(3);
      lift_thr_q <= CntW'(3);
      flip_q     <= 1'b0;
      poll_q     <= 1'b0;
      deb_q      <= '1;
      chg_q      <= '0;
      rd_idx_q   <= '0;
      s1_vld_q   <= 1'b0;
      s1_idx_q   <= '0;
      emit_idx_q <= '0;
      evt_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_wr) begin
        unique case (paddr[3:2])
          RegDrop: drop_thr_q <= pwdata[CntW-1:0];
          RegLift: lift_thr_q <= pwdata[CntW-1:0];
          RegFlip: flip_q     <= pwdata[0];
          RegPoll: poll_q     <= pwdata[0];
          default: ;
        endcase
      end

      // start and resume
      if (clr_all) begin
        poll_q <= 1'b1;
        if (mode_e'(cmd_i.mode) == ModeStart) begin
          deb_q <= '1;
        end
      end

      // tick start
      if (tick_go) begin
        rd_idx_q   <= '0;
        chg_q      <= '0;
        emit_idx_q <= '0;
      end

      // walk: read stage then update stage
      s1_vld_q <= walk_rd;
      if (walk_rd) begin
        s1_idx_q <= rd_idx_q[CntAddrW-1:0];
        rd_idx_q <= rd_idx_q + WalkIdxW'(1);
      end
      if (s1_vld_q && hit) begin
        deb_q[s1_idx_q] <= ~cur_bit;
        chg_q[s1_idx_q] <= 1'b1;
      end

      // event scan
      if (emit_load) begin
        chg_q[emit_idx_q] <= 1'b0;
      end
      if (emit_load || emit_skip) begin
        emit_idx_q <= emit_idx_q + CntAddrW'(1);
      end

      // output slot
      if (emit_load) begin
        evt_vld_q <= 1'b1;
      end else if (evt_o.ready) begin
        evt_vld_q <= 1'b0;
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      sample_q <= ~(flip_q ? rev_word(cmd_i.raw_rows) : cmd_i.raw_rows);
    end
    if (emit_load) begin
      evt_sq_q   <= SquareW'(emit_idx_q);
      evt_lift_q <= deb_q[emit_idx_q];
      evt_last_q <= (emit_rest == '0);
      evt_occ_q  <= rev_word(~deb_q);
    end
  end

  assign evt_o.valid      = evt_vld_q;
  assign evt_o.square     = evt_sq_q;
  assign evt_o.lifted     = evt_lift_q;
  assign evt_o.last_event = evt_last_q;
  assign evt_o.occupancy  = evt_occ_q;

endmodule

[bench/tb_multi_switch_debounce_events_unit.sv]
module tb_multi_switch_debounce_events_unit
  import msde_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // the fourth mode code, which the block must ignore
  localparam logic [ModeW-1:0] ModeUndef = 2'd3;
  localparam int SettleCycles = 200;
  localparam int NumPhases    = 7;

  typedef struct packed {
    logic [SquareW-1:0] square;
    logic               lifted;
    logic               last_event;
    logic [WordW-1:0]   occupancy;
  } change_t;

  // directed row: n_changes < 0 means checked by the predictor only
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [WordW-1:0] raw;
    int               n_changes;
    logic [WordW-1:0] occ;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PaddrW-1:0] paddr;
  logic [PdataW-1:0] pwdata;
  logic [PdataW-1:0] prdata;
  logic              pready;

  msde_cmd_if cmd ();
  msde_evt_if evt ();

  multi_switch_debounce_events_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .evt_o   (evt),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // debouncer shadow state and register copies
  logic [WordW-1:0] deb_state;
  logic [CntW-1:0]  hold_cnt [NumSwitches];
  logic [CntW-1:0]  cfg_drop;
  logic [CntW-1:0]  cfg_lift;
  logic             cfg_flip;
  logic             cfg_poll;

  change_t pending_changes[$];
  int      mismatches = 0;
  bit      calm = 1'b0;

  row_t steps [24];

  // per-phase register settings and item counts
  int unsigned ph_drop  [NumPhases] = '{2, 0, 1, 255, 5, 3, 255};
  int unsigned ph_lift  [NumPhases] = '{3, 0, 4, 255, 2, 1, 0};
  int unsigned ph_flip  [NumPhases] = '{1, 0, 1, 0, 0, 1, 1};
  int unsigned ph_poll  [NumPhases] = '{1, 1, 0, 1, 1, 1, 1};
  int unsigned ph_items [NumPhases] = '{45, 35, 35, 18, 45, 45, 27};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [WordW-1:0] mirror64(input logic [WordW-1:0] v);
    logic [WordW-1:0] r;
    for (int k = 0; k < WordW; k++) r[k] = v[WordW-1-k];
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // Apply one accepted item to the shadow debouncer; queue the changes it makes
  function automatic int step_debouncer(input logic [ModeW-1:0] md,
                                        input logic [WordW-1:0] raw);
    logic [WordW-1:0]   smp;
    logic [WordW-1:0]   diff;
    logic [WordW-1:0]   occ;
    logic [SquareW-1:0] sq [NumSwitches];
    logic               kind [NumSwitches];
    change_t            c;
    int                 n;
    n = 0;
    case (md)
      ModeStart, ModeResume: begin
        for (int i = 0; i < NumSwitches; i++) hold_cnt[i] = '0;
        if (md == ModeStart) deb_state = '1;
        cfg_poll = 1'b1;
        return 0;
      end
      ModeTick: if (!cfg_poll) return 0;
      default: return 0;
    endcase
    smp  = cfg_flip ? mirror64(raw) : raw;
    smp  = ~smp;
    diff = deb_state ^ smp;
    for (int i = 0; i < NumSwitches; i++) begin
      if (diff[i]) begin
        hold_cnt[i] = hold_cnt[i] + 1'b1;
        if (deb_state[i] ? (hold_cnt[i] >= cfg_drop) : (hold_cnt[i] >= cfg_lift)) begin
          kind[n]      = ~deb_state[i];
          sq[n]        = SquareW'(i);
          deb_state[i] = ~deb_state[i];
          hold_cnt[i]  = '0;
          n++;
        end
      end else begin
        hold_cnt[i] = '0;
      end
    end
    occ = mirror64(~deb_state);
    for (int i = 0; i < n; i++) begin
      c.square     = sq[i];
      c.lifted     = kind[i];
      c.last_event = (i == n - 1);
      c.occupancy  = occ;
      pending_changes.push_back(c);
    end
    return n;
  endfunction

  // Offer one command item after a random gap; predict at acceptance
  task automatic push_cmd(input logic [ModeW-1:0] md, input logic [WordW-1:0] raw,
                          output int n);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.valid    <= 1'b1;
    cmd.mode     <= md;
    cmd.raw_rows <= raw;
    do @(posedge clk_i); while (!cmd.ready);
    n = step_debouncer(md, raw);
  endtask

  // APB write: setup phase, then access phase, then back to idle
  task automatic reg_write(input logic [1:0] idx, input logic [PdataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PaddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegDrop: cfg_drop = val[CntW-1:0];
      RegLift: cfg_lift = val[CntW-1:0];
      RegFlip: cfg_flip = val[0];
      RegPoll: cfg_poll = val[0];
      default: ;
    endcase
  endtask

  // Drop valid, drain expected changes, then let a silent walk finish
  task automatic wait_idle();
    cmd.valid <= 1'b0;
    while (pending_changes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Event side: random stall before each item
  initial begin
    int stall;
    evt.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        evt.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      evt.ready <= 1'b1;
      do @(posedge clk_i); while (!evt.valid);
    end
  end

  // Compare each accepted event with the oldest expected change
  always @(posedge clk_i) begin
    change_t want;
    if (rst_ni && evt.valid && evt.ready) begin
      if (pending_changes.size() == 0) begin
        flag($sformatf("unexpected event square %0d lifted %0d", evt.square, evt.lifted));
      end else begin
        want = pending_changes.pop_front();
        if (evt.square !== want.square)
          flag($sformatf("square exp %0d got %0d", want.square, evt.square));
        if (evt.lifted !== want.lifted)
          flag($sformatf("lifted exp %0d got %0d (square %0d)",
                         want.lifted, evt.lifted, want.square));
        if (evt.last_event !== want.last_event)
          flag($sformatf("last_event exp %0d got %0d (square %0d)",
                         want.last_event, evt.last_event, want.square));
        if (evt.occupancy !== want.occupancy)
          flag($sformatf("occupancy exp %h got %h", want.occupancy, evt.occupancy));
      end
    end
  end

  initial begin
    logic [WordW-1:0] board;
    logic [ModeW-1:0] md;
    logic [WordW-1:0] raw;
    int               n;
    int               done;
    int               r;
    bit               skip;

    cmd.valid    <= 1'b0;
    cmd.mode     <= ModeTick;
    cmd.raw_rows <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    rst_ni       <= 1'b0;

    deb_state = '1;
    for (int i = 0; i < NumSwitches; i++) hold_cnt[i] = '0;
    cfg_drop = 8'd3;
    cfg_lift = 8'd3;
    cfg_flip = 1'b0;
    cfg_poll = 1'b0;

    // directed rows under the reset register values (drop 3, lift 3)
    steps = '{
      '{ModeTick,   64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0},   // polling off: ignored
      '{ModeUndef,  64'hA5A5_5A5A_C3C3_3C3C, 0, 64'h0},
      '{ModeStart,  64'h0,                   0, 64'h0},
      '{ModeTick,   64'h0,                   0, 64'h0},
      '{ModeTick,   64'h1,                   0, 64'h0},
      '{ModeTick,   64'h1,                   0, 64'h0},
      '{ModeTick,   64'h1,                   1, 64'h8000_0000_0000_0000},
      '{ModeTick,   64'h8000_0000_0000_0001, 0, 64'h0},
      '{ModeTick,   64'h8000_0000_0000_0001, 0, 64'h0},
      '{ModeTick,   64'h8000_0000_0000_0001, 1, 64'h8000_0000_0000_0001},
      '{ModeTick,   64'h0,                   0, 64'h0},
      '{ModeTick,   64'h0,                   0, 64'h0},
      '{ModeTick,   64'h0,                   2, 64'h0},
      '{ModeTick,   64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0},   // bounce clears counters
      '{ModeTick,   64'h0,                   0, 64'h0},
      '{ModeTick,   64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0},
      '{ModeTick,   64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0},
      '{ModeResume, 64'h0,                   0, 64'h0},   // counters back to zero
      '{ModeTick,   64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0},
      '{ModeTick,   64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0},
      '{ModeTick,   64'hFFFF_FFFF_FFFF_FFFF, 64, 64'hFFFF_FFFF_FFFF_FFFF},
      '{ModeStart,  64'h0,                   0, 64'h0},
      '{ModeTick,   64'h0,                   0, 64'h0},
      '{ModeTick,   64'h0123_4567_89AB_CDEF, -1, 64'h0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[k]) begin
      push_cmd(steps[k].mode, steps[k].raw, n);
      if (steps[k].n_changes >= 0) begin
        if (n != steps[k].n_changes)
          flag($sformatf("row %0d: %0d changes predicted, %0d listed",
                         k, n, steps[k].n_changes));
        else if (n > 0 && pending_changes[$].occupancy !== steps[k].occ)
          flag($sformatf("row %0d: occupancy predicted %h, listed %h",
                         k, pending_changes[$].occupancy, steps[k].occ));
      end
    end

    // random phases: mostly held board patterns with bounces, plus noise
    board = '0;
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      reg_write(RegDrop, ph_drop[p]);
      reg_write(RegLift, ph_lift[p]);
      reg_write(RegFlip, ph_flip[p]);
      reg_write(RegPoll, ph_poll[p]);
      calm = (p == 4);
      done = 0;
      while (done < ph_items[p]) begin
        r   = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        if (r < 4) begin
          md = ModeStart;
        end else if (r < 8) begin
          md = ModeResume;
        end else if (r < 10) begin
          md = ModeUndef;
        end else if (r < 20) begin
          md = ModeTick;
        end else begin
          md = ModeTick;
          r  = $urandom_range(0, 99);
          if (r < 30) begin
            repeat ($urandom_range(1, 4)) board[$urandom_range(0, WordW - 1)] ^= 1'b1;
          end else if (r < 35) begin
            board = {$urandom, $urandom};
          end else if (r < 38) begin
            board = '1;
          end else if (r < 41) begin
            board = '0;
          end
          raw = board;
        end
        skip = (md == ModeUndef) || (md == ModeTick && !cfg_poll);
        push_cmd(md, raw, n);
        if (!skip) done++;
      end
    end

    wait_idle();
    if (mismatches == 0 && pending_changes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
